@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the priority queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset.
`define DSPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define DSPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hw/rtl/dspq_pkg.sv @@
// ----------------------------------------------------------------------------
// dspq_pkg
// Shared constants, codes and types of the dual strand priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dspq_pkg;
    localparam int STRAND_DEPTH = 64;
    localparam int ADDR_W       = $clog2(STRAND_DEPTH);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int CAP_W        = (CNT_W > 8) ? CNT_W : 8;
    localparam int KEY_W        = 64;
    localparam int ELEM_W       = 64;
    localparam int ENTRY_W      = KEY_W + ELEM_W;
    localparam int PADDR_W      = 4;

    localparam logic [2:0] OP_INS_FIFO  = 3'd0;
    localparam logic [2:0] OP_INS_VT    = 3'd1;
    localparam logic [2:0] OP_POP       = 3'd2;
    localparam logic [2:0] OP_POP_SEL   = 3'd3;
    localparam logic [2:0] OP_PEEK      = 3'd4;
    localparam logic [2:0] OP_PEEK_SEL  = 3'd5;

    localparam logic [1:0] SEL_A    = 2'd0;
    localparam logic [1:0] SEL_AUTO = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_Q_FULL    = 3'd1;
    localparam logic [2:0] ST_IMBAL     = 3'd2;
    localparam logic [2:0] ST_WRONG     = 3'd3;
    localparam logic [2:0] ST_S_FULL    = 3'd4;

    localparam logic [1:0] PM_ALT  = 2'd0;
    localparam logic [1:0] PM_LOW  = 2'd1;
    localparam logic [1:0] PM_BAL  = 2'd2;

    localparam logic [1:0] REG_FIFO_MODE = 2'd0;
    localparam logic [1:0] REG_TOTAL_CAP = 2'd1;
    localparam logic [1:0] REG_POP_MODE  = 2'd2;
    localparam logic [1:0] REG_IMB_LIMIT = 2'd3;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_HEAD = 6'b000100,
        S_SRD  = 6'b001000,
        S_SCMP = 6'b010000,
        S_DONE = 6'b100000
    } t_state;
endpackage
`default_nettype wire

@@ hw/rtl/dspq_in_if.sv @@
// ----------------------------------------------------------------------------
// dspq_in_if
// Request channel: one item per valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface dspq_in_if import dspq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        opcode;
    logic [1:0]        strand_select;
    logic [ELEM_W-1:0] element;
    logic [KEY_W-1:0]  vtime_key;

    modport source (output valid, opcode, strand_select, element, vtime_key, input ready);
    modport sink   (input valid, opcode, strand_select, element, vtime_key, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/dspq_out_if.sv @@
// ----------------------------------------------------------------------------
// dspq_out_if
// Result channel: one item per valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface dspq_out_if import dspq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic              found;
    logic [ELEM_W-1:0] result_element;
    logic [6:0]        count_a;
    logic [6:0]        count_b;

    modport source (output valid, status, found, result_element, count_a, count_b,
                    input ready);
    modport sink   (input valid, status, found, result_element, count_a, count_b,
                    output ready);
endinterface
`default_nettype wire

@@ hw/rtl/dspq_ram.sv @@
// ----------------------------------------------------------------------------
// dspq_ram
// Simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dspq_ram #(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 128
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [DATA_BITS-1:0] i_wdata,
    input  wire logic [ADDR_BITS-1:0] i_raddr,
    output logic      [DATA_BITS-1:0] o_rdata
);
    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/dual_strand_priority_queue.sv @@
// Two key-ordered strands, each a circular buffer in its own RAM. Each item is
// accepted in S_IDLE, then passes S_RD and S_HEAD; pop, peek, refused inserts
// and unused opcodes go straight on to S_DONE. An insert walks its strand from
// the tail toward the head, reading an entry in S_SRD and rewriting it in
// S_SCMP, until it meets an entry whose key is no larger or reaches the head.
// The block accepts one item at a time; one result may wait at the output
// while the next item is worked.
// ----------------------------------------------------------------------------
// dual_strand_priority_queue
// Top level: sequencer, strand RAMs, APB register file and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dual_strand_priority_queue import dspq_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    dspq_in_if.sink                 i_in,
    dspq_out_if.source              o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);
    t_state             r_state, n_state;
    logic [2:0]         r_op;
    logic [1:0]         r_sel;
    logic [ELEM_W-1:0]  r_elem;
    logic [KEY_W-1:0]   r_vkey;
    logic [KEY_W-1:0]   r_key;
    logic               r_t;
    logic [CNT_W-1:0]   r_pos;
    logic [CNT_W-1:0]   r_size [2];
    logic [ADDR_W-1:0]  r_head [2];
    logic [KEY_W-1:0]   r_seq  [2];
    logic               r_last;
    logic [2:0]         r_status;
    logic               r_found;
    logic [ELEM_W-1:0]  r_res;

    logic               r_fifo;
    logic [7:0]         r_cap;
    logic [1:0]         r_popm;
    logic [7:0]         r_imb;

    logic               r_ovalid;
    logic [2:0]         r_ostatus;
    logic               r_ofound;
    logic [ELEM_W-1:0]  r_ores;
    logic [6:0]         r_ocnt_a;
    logic [6:0]         r_ocnt_b;

    logic               w_we    [2];
    logic [ADDR_W-1:0]  w_waddr [2];
    logic [ENTRY_W-1:0] w_wdata [2];
    logic [ADDR_W-1:0]  w_raddr [2];
    logic [ENTRY_W-1:0] w_rd    [2];

    logic               w_tgt, w_wrong, w_full, w_imbal, w_sfull;
    logic [KEY_W-1:0]   w_key;
    logic [CNT_W:0]     w_sum;
    logic [CNT_W-1:0]   w_my, w_oth;
    logic [CAP_W-1:0]   w_half, w_scap;
    logic [2:0]         w_istat;
    logic               w_alt_t, w_cho_t, w_cho_ok, w_pt, w_pok;
    logic               w_accept, w_out_free, w_gt;
    logic [ADDR_W-1:0]  w_off;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // insert checks
    always_comb begin
        w_tgt   = (r_sel == SEL_AUTO) ? (r_size[0] > r_size[1]) : (r_sel != SEL_A);
        w_wrong = ((r_op == OP_INS_VT) == r_fifo);
        w_key   = (r_op == OP_INS_VT) ? r_vkey : r_seq[w_tgt];
        w_sum   = {1'b0, r_size[0]} + {1'b0, r_size[1]};
        w_my    = r_size[w_tgt];
        w_oth   = r_size[!w_tgt];
        w_full  = ({{(CAP_W + 1 - CNT_W - 1){1'b0}}, w_sum} >= {1'b0, CAP_W'(r_cap)});
        w_imbal = (r_imb != 8'd0) &&
                  ({{(CAP_W + 2 - CNT_W){1'b0}}, w_my} >=
                   {{(CAP_W + 2 - CNT_W){1'b0}}, w_oth} + {2'b0, CAP_W'(r_imb)});
        w_half  = CAP_W'(r_cap >> 1);
        w_scap  = (w_half > CAP_W'(STRAND_DEPTH)) ? CAP_W'(STRAND_DEPTH) : w_half;
        w_sfull = ({{(CAP_W - CNT_W){1'b0}}, w_my} >= w_scap);
        if (w_wrong) begin
            w_istat = ST_WRONG;
        end else if (w_full) begin
            w_istat = ST_Q_FULL;
        end else if (w_imbal) begin
            w_istat = ST_IMBAL;
        end else if (w_sfull) begin
            w_istat = ST_S_FULL;
        end else begin
            w_istat = ST_OK;
        end
    end

    // pop / peek strand choice
    always_comb begin
        w_alt_t  = !r_last;
        if (r_size[w_alt_t] == '0) begin
            w_alt_t = r_last;
        end
        w_cho_ok = (w_sum != '0);
        case (r_popm)
            PM_ALT:  w_cho_t = w_alt_t;
            PM_LOW:  w_cho_t = !((r_size[0] != '0) && ((r_size[1] == '0) ||
                               (w_rd[0][ENTRY_W-1:ELEM_W] <= w_rd[1][ENTRY_W-1:ELEM_W])));
            PM_BAL:  w_cho_t = (r_size[0] < r_size[1]);
            default: begin
                w_cho_t  = 1'b0;
                w_cho_ok = 1'b0;
            end
        endcase
        if (r_op == OP_POP || r_op == OP_PEEK) begin
            w_pt  = w_cho_t;
            w_pok = w_cho_ok;
        end else begin
            w_pt  = (r_sel != SEL_A);
            w_pok = (r_size[w_pt] != '0);
        end
    end

    // RAM ports
    always_comb begin
        w_off = r_pos[ADDR_W-1:0];
        w_gt  = (w_rd[r_t][ENTRY_W-1:ELEM_W] > r_key);
        for (int i = 0; i < 2; i++) begin
            w_raddr[i] = r_head[i];
            w_we[i]    = 1'b0;
            w_waddr[i] = r_head[i] + w_off;
            w_wdata[i] = {r_key, r_elem};
        end
        if (r_state == S_SRD) begin
            w_raddr[r_t] = r_head[r_t] + w_off - ADDR_W'(1);
            w_we[r_t]    = (r_pos == '0);
        end
        if (r_state == S_SCMP) begin
            w_we[r_t] = 1'b1;
            if (w_gt) begin
                w_wdata[r_t] = w_rd[r_t];
            end
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_strand
        dspq_ram #(.ADDR_BITS(ADDR_W), .DATA_BITS(ENTRY_W)) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[g]),
            .i_waddr (w_waddr[g]),
            .i_wdata (w_wdata[g]),
            .i_raddr (w_raddr[g]),
            .o_rdata (w_rd[g])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) n_state = S_RD;
            S_RD:   n_state = S_HEAD;
            S_HEAD: begin
                if ((r_op == OP_INS_FIFO || r_op == OP_INS_VT) && w_istat == ST_OK) begin
                    n_state = S_SRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SRD:  n_state = (r_pos == '0) ? S_DONE : S_SCMP;
            S_SCMP: n_state = w_gt ? S_SRD : S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_size   <= '{default: '0};
            r_head   <= '{default: '0};
            r_seq    <= '{default: '0};
            r_last   <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_out.ready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op     <= i_in.opcode;
                        r_sel    <= i_in.strand_select;
                        r_elem   <= i_in.element;
                        r_vkey   <= i_in.vtime_key;
                        r_status <= ST_OK;
                        r_found  <= 1'b0;
                        r_res    <= '0;
                    end
                end
                S_HEAD: begin
                    case (r_op)
                        OP_INS_FIFO, OP_INS_VT: begin
                            r_status <= w_istat;
                            if (!w_wrong && r_op == OP_INS_FIFO) begin
                                r_seq[w_tgt] <= r_seq[w_tgt] + KEY_W'(1);
                            end
                            r_t   <= w_tgt;
                            r_key <= w_key;
                            r_pos <= w_my;
                        end
                        OP_POP, OP_POP_SEL, OP_PEEK, OP_PEEK_SEL: begin
                            if (w_pok) begin
                                r_found <= 1'b1;
                                r_res   <= w_rd[w_pt][ELEM_W-1:0];
                                if (r_op == OP_POP || r_op == OP_POP_SEL) begin
                                    r_head[w_pt] <= r_head[w_pt] + ADDR_W'(1);
                                    r_size[w_pt] <= r_size[w_pt] - CNT_W'(1);
                                end
                                if (r_op == OP_POP) begin
                                    r_last <= w_pt;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_SRD: begin
                    if (r_pos == '0) begin
                        r_size[r_t] <= r_size[r_t] + CNT_W'(1);
                    end
                end
                S_SCMP: begin
                    if (w_gt) begin
                        r_pos <= r_pos - CNT_W'(1);
                    end else begin
                        r_size[r_t] <= r_size[r_t] + CNT_W'(1);
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_status;
                        r_ofound  <= r_found;
                        r_ores    <= r_res;
                        r_ocnt_a  <= 7'(r_size[0]);
                        r_ocnt_b  <= 7'(r_size[1]);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.status         = r_ostatus;
    assign o_out.found          = r_ofound;
    assign o_out.result_element = r_ores;
    assign o_out.count_a        = r_ocnt_a;
    assign o_out.count_b        = r_ocnt_b;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo <= 1'b1;
            r_cap  <= 8'd128;
            r_popm <= PM_ALT;
            r_imb  <= 8'd0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_FIFO_MODE: r_fifo <= pwdata[0];
                REG_TOTAL_CAP: r_cap  <= pwdata[7:0];
                REG_POP_MODE:  r_popm <= pwdata[1:0];
                REG_IMB_LIMIT: r_imb  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FIFO_MODE: prdata = {31'd0, r_fifo};
            REG_TOTAL_CAP: prdata = {24'd0, r_cap};
            REG_POP_MODE:  prdata = {30'd0, r_popm};
            REG_IMB_LIMIT: prdata = {24'd0, r_imb};
            default:       prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    `DSPQ_ASSERT(a_size_a_max, (r_size[0] <= CNT_W'(STRAND_DEPTH)), "strand A overfilled")
    `DSPQ_ASSERT(a_size_b_max, (r_size[1] <= CNT_W'(STRAND_DEPTH)), "strand B overfilled")
    `DSPQ_ASSERT(a_accept_seq, (w_accept |=> (r_state == S_RD)), "accept did not start read")
    `DSPQ_ASSERT(a_walk_bound, ((r_state == S_SCMP) |-> (r_pos != '0)), "walk past head")
endmodule
`default_nettype wire

@@ tb/dspq_checker.sv @@
// ----------------------------------------------------------------------------
// dspq_checker
// Watches the request, result and register ports of the priority queue. It
// keeps its own copy of both strands, works out the result of each accepted
// request, and compares every accepted result field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dspq_checker import dspq_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    dspq_in_if                      in_mon,
    dspq_out_if                     out_mon,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic               pready,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output int                      o_errors,
    output int                      o_pending,
    output int                      o_checked
);
    typedef struct packed {
        logic [2:0]        status;
        logic              found;
        logic [ELEM_W-1:0] elem;
        logic [6:0]        cnt_a;
        logic [6:0]        cnt_b;
    } t_outcome;

    t_outcome          outcome_q[$];
    logic [KEY_W-1:0]  skey[2][STRAND_DEPTH];
    logic [ELEM_W-1:0] selem[2][STRAND_DEPTH];
    int unsigned       cnt[2];
    logic [KEY_W-1:0]  seqn[2];
    int unsigned       last_side;
    bit                fifo_md;
    int unsigned       cap;
    logic [1:0]        pmode;
    int unsigned       imb_lim;

    function automatic int unsigned pick_side();
        int unsigned t;
        if (cnt[0] + cnt[1] == 0) return 2;
        case (pmode)
            PM_ALT: begin
                t = last_side ^ 1;
                if (cnt[t] == 0) t ^= 1;
                return t;
            end
            PM_LOW: return (cnt[0] > 0 && (cnt[1] == 0 || skey[0][0] <= skey[1][0])) ? 0 : 1;
            PM_BAL: return (cnt[0] >= cnt[1]) ? 0 : 1;
            default: return 2;
        endcase
    endfunction

    function automatic logic [2:0] try_insert(bit vt, logic [1:0] sel,
                                              logic [63:0] el, logic [63:0] vkey);
        int unsigned t, scap, pos;
        logic [63:0] k;
        if (vt == fifo_md) return ST_WRONG;
        if (sel == SEL_AUTO) t = (cnt[0] <= cnt[1]) ? 0 : 1;
        else t = (sel == SEL_A) ? 0 : 1;
        if (vt) begin
            k = vkey;
        end else begin
            k = seqn[t];
            seqn[t] = seqn[t] + 1;
        end
        if (cnt[0] + cnt[1] >= cap) return ST_Q_FULL;
        if (imb_lim > 0 && cnt[t] >= cnt[t ^ 1] + imb_lim) return ST_IMBAL;
        scap = (cap / 2 > STRAND_DEPTH) ? STRAND_DEPTH : cap / 2;
        if (cnt[t] >= scap) return ST_S_FULL;
        pos = cnt[t];
        while (pos > 0 && skey[t][pos-1] > k) begin
            skey[t][pos] = skey[t][pos-1];
            selem[t][pos] = selem[t][pos-1];
            pos--;
        end
        skey[t][pos] = k;
        selem[t][pos] = el;
        cnt[t]++;
        return ST_OK;
    endfunction

    function automatic logic [63:0] take_head(int unsigned t);
        logic [63:0] e;
        e = selem[t][0];
        for (int i = 1; i < cnt[t]; i++) begin
            skey[t][i-1] = skey[t][i];
            selem[t][i-1] = selem[t][i];
        end
        cnt[t]--;
        return e;
    endfunction

    function automatic t_outcome predict_request(logic [2:0] op, logic [1:0] sel,
                                                 logic [63:0] el, logic [63:0] vkey);
        t_outcome r;
        int unsigned t;
        r = '0;
        case (op)
            OP_INS_FIFO, OP_INS_VT: r.status = try_insert(op == OP_INS_VT, sel, el, vkey);
            OP_POP: begin
                t = pick_side();
                if (t < 2) begin
                    r.elem = take_head(t);
                    r.found = 1'b1;
                    last_side = t;
                end
            end
            OP_POP_SEL: begin
                t = (sel == SEL_A) ? 0 : 1;
                if (cnt[t] > 0) begin
                    r.elem = take_head(t);
                    r.found = 1'b1;
                end
            end
            OP_PEEK: begin
                t = pick_side();
                if (t < 2) begin
                    r.elem = selem[t][0];
                    r.found = 1'b1;
                end
            end
            OP_PEEK_SEL: begin
                t = (sel == SEL_A) ? 0 : 1;
                if (cnt[t] > 0) begin
                    r.elem = selem[t][0];
                    r.found = 1'b1;
                end
            end
            default: ;
        endcase
        r.cnt_a = cnt[0][6:0];
        r.cnt_b = cnt[1][6:0];
        return r;
    endfunction

    task automatic cmp_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: mismatch on %s: expected %0h, got %0h", $time, fname, exp_v, act_v);
            o_errors++;
        end
    endtask

    assign o_pending = outcome_q.size();

    initial begin
        o_errors = 0;
        o_checked = 0;
    end

    always @(posedge i_clk) begin
        t_outcome exp_r;
        if (!i_rst_n) begin
            outcome_q.delete();
            cnt[0] = 0;
            cnt[1] = 0;
            seqn[0] = '0;
            seqn[1] = '0;
            last_side = 1;
            fifo_md = 1'b1;
            cap = 128;
            pmode = PM_ALT;
            imb_lim = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_FIFO_MODE: fifo_md = pwdata[0];
                    REG_TOTAL_CAP: cap = 32'(pwdata[7:0]);
                    REG_POP_MODE:  pmode = pwdata[1:0];
                    REG_IMB_LIMIT: imb_lim = 32'(pwdata[7:0]);
                    default: ;
                endcase
            end
            if (out_mon.valid && out_mon.ready) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: result with none expected: status %0d found %0b elem %0h",
                             $time, out_mon.status, out_mon.found, out_mon.result_element);
                    o_errors++;
                end else begin
                    exp_r = outcome_q.pop_front();
                    cmp_field("status", 64'(exp_r.status), 64'(out_mon.status));
                    cmp_field("found", 64'(exp_r.found), 64'(out_mon.found));
                    cmp_field("result_element", exp_r.elem, out_mon.result_element);
                    cmp_field("count_a", 64'(exp_r.cnt_a), 64'(out_mon.count_a));
                    cmp_field("count_b", 64'(exp_r.cnt_b), 64'(out_mon.count_b));
                    o_checked++;
                end
            end
            if (in_mon.valid && in_mon.ready)
                outcome_q.push_back(predict_request(in_mon.opcode, in_mon.strand_select,
                                                    in_mon.element, in_mon.vtime_key));
        end
    end
endmodule
`default_nettype wire

@@ tb/dual_strand_priority_queue_tb.sv @@
// ----------------------------------------------------------------------------
// dual_strand_priority_queue_tb
// Drives requests and register writes into the priority queue under random
// idling on both channels save one phase; a checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dual_strand_priority_queue_tb;
    import dspq_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 errors;
    int                 pending;
    int                 checked;
    int                 sent;
    int                 settings;
    bit                 no_idle;
    bit                 fifo_now;

    dspq_in_if  in_bus();
    dspq_out_if out_bus();

    dual_strand_priority_queue uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_bus), .o_out(out_bus),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    dspq_checker ck (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_mon(in_bus), .out_mon(out_bus),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge i_clk)
        out_bus.ready <= no_idle || ($urandom_range(99) >= 17);

    task automatic send_req(logic [2:0] op, logic [1:0] sel, logic [63:0] el,
                            logic [63:0] vkey);
        if (!no_idle && $urandom_range(99) < 17) begin
            in_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 40);
        end
        in_bus.valid <= 1'b1;
        in_bus.opcode <= op;
        in_bus.strand_select <= sel;
        in_bus.element <= el;
        in_bus.vtime_key <= vkey;
        do @(posedge i_clk); while (!in_bus.ready);
        sent++;
    endtask

    task automatic drain();
        in_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic run_phase(bit fifo, int cap, int pm, int imb, int n, int ins_pct,
                             int sel_fix);
        logic [2:0]  op;
        logic [1:0]  sel;
        logic [63:0] el;
        logic [63:0] vkey;
        int          r;
        drain();
        reg_write(REG_FIFO_MODE, 32'(fifo));
        reg_write(REG_TOTAL_CAP, 32'(cap));
        reg_write(REG_POP_MODE, 32'(pm));
        reg_write(REG_IMB_LIMIT, 32'(imb));
        fifo_now = fifo;
        settings++;
        repeat (n) begin
            if ($urandom_range(99) < ins_pct) begin
                if ($urandom_range(99) < 88) op = fifo_now ? OP_INS_FIFO : OP_INS_VT;
                else op = fifo_now ? OP_INS_VT : OP_INS_FIFO;
            end else begin
                op = ($urandom_range(99) < 6) ? 3'($urandom_range(7, 6))
                                              : 3'($urandom_range(5, 2));
            end
            sel = (sel_fix >= 0) ? 2'(sel_fix) : 2'($urandom_range(3));
            r = $urandom_range(99);
            el = (r < 5) ? 64'd0 : (r < 10) ? '1 : rand64();
            r = $urandom_range(99);
            vkey = (r < 5) ? 64'd0 : (r < 10) ? '1 :
                   (r < 40) ? 64'($urandom_range(7)) : rand64();
            send_req(op, sel, el, vkey);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_bus.valid <= 1'b0;
        in_bus.opcode <= OP_INS_FIFO;
        in_bus.strand_select <= SEL_A;
        in_bus.element <= '0;
        in_bus.vtime_key <= '0;
        sent = 0;
        settings = 1;
        no_idle = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: fifo keys, alternating pops
        send_req(OP_INS_FIFO, SEL_A, 64'd1, '0);
        send_req(OP_INS_FIFO, 2'd1, '1, '1);
        send_req(OP_INS_FIFO, SEL_AUTO, 64'd0, '0);
        send_req(OP_INS_FIFO, 2'd3, 64'd5, '0);
        send_req(OP_INS_VT, SEL_A, 64'd9, 64'd3);
        send_req(OP_PEEK, SEL_A, '1, '1);
        send_req(OP_PEEK_SEL, SEL_A, '0, '0);
        send_req(OP_PEEK_SEL, 2'd3, '0, '0);
        send_req(OP_POP, SEL_A, '0, '0);
        send_req(OP_POP, SEL_AUTO, '0, '0);
        send_req(OP_POP_SEL, SEL_A, '0, '0);
        send_req(OP_POP_SEL, SEL_AUTO, '0, '0);
        send_req(OP_POP, SEL_A, '0, '0);
        send_req(OP_PEEK, SEL_A, '0, '0);
        send_req(OP_POP_SEL, 2'd1, '0, '0);
        send_req(OP_PEEK_SEL, SEL_A, '0, '0);
        send_req(3'd6, 2'd3, '1, '1);
        send_req(3'd7, SEL_A, '1, '0);

        run_phase(1, 128, PM_ALT, 0, 90, 60, -1);
        run_phase(1, 128, PM_LOW, 0, 75, 100, SEL_A);
        run_phase(0, 21, PM_LOW, 0, 70, 55, -1);
        no_idle = 1'b1;
        run_phase(0, 128, PM_BAL, 3, 80, 60, -1);
        no_idle = 1'b0;
        run_phase(1, 0, 3, 128, 30, 50, -1);
        run_phase(0, 127, PM_ALT, 1, 60, 50, -1);
        run_phase(1, 128, PM_LOW, 0, 80, 10, -1);
        drain();

        $display("Covered %0d requests over %0d register settings; %0d results checked.",
                 sent, settings, checked);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
